FILE: rtl/olrs_pkg.sv
// Package for the opening log-return share block: widths, defaults and the
// controller state type. Used by opening_log_return_share; depends on nothing.
package olrs_pkg;

	// Fixed field widths
	localparam int PRICE_W    = 32;
	localparam int RATIO_W    = 32;
	localparam int RATIO_FRAC = 16;
	localparam int LOG_INT_W  = 5;

	// Defaults for the top-level parameters
	localparam int OPENING_RETURNS_DEF = 6;
	localparam int LOG_FRAC_BITS_DEF   = 16;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_LOG,
		ST_ACC,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} olrs_state_t;

endpackage

FILE: rtl/opening_log_return_share.sv
// Top level of the opening log-return share block: normaliser, squaring log2,
// accumulator and bit-serial divider. Depends on olrs_pkg.
//
// Usage: price samples of one series enter on the s_ channel, s_tlast marking
// the final sample. A price of zero counts as missing. For each sample the block
// forms log2(price) in fixed point, sums the log differences of the first
// OPENING_RETURNS adjacent pairs, and on the final sample sends one item on the
// m_ channel: the sum scaled by 2^16 and divided by L(last) - L(first),
// truncated toward zero and saturated to signed 32 bits. m_tuser[0] low means
// the ratio has no defined value and the data is zero.
// Timing: one sample is taken at a time. A present sample is accepted, then
// normalised a nibble or a bit at a time, squared once per fraction bit (one
// 32x32 multiply per cycle) and accumulated. A missing sample goes straight
// from acceptance to accumulation. The final sample adds a setup step, then,
// when the ratio is defined, a restoring division with one quotient bit per
// numerator bit (41 at the defaults), and the load of the output register.
// Reset: the series state returns to the start of a new series and no result
// is pending. Stall: the result waits in the output register; the next samples
// are still taken, and only a further result waits until the pending one goes.
module opening_log_return_share #(
	parameter int OPENING_RETURNS = olrs_pkg::OPENING_RETURNS_DEF,
	parameter int LOG_FRAC_BITS   = olrs_pkg::LOG_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input items
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [olrs_pkg::PRICE_W-1:0] s_tdata,   // [31:0] price
	input  logic                         s_tlast,   // last sample of the series
	// result items
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [olrs_pkg::RATIO_W-1:0] m_tdata,   // [31:0] ratio (signed)
	output logic [0:0]                   m_tuser    // [0] valid_res
);
	import olrs_pkg::*;

	localparam int LOG_W   = LOG_INT_W + LOG_FRAC_BITS;
	localparam int PC_W    = $clog2(OPENING_RETURNS + 1);
	localparam int SUM_W   = LOG_W + PC_W + 1;
	localparam int NUM_W   = SUM_W + RATIO_FRAC;
	localparam int Q_W     = (NUM_W > RATIO_W) ? NUM_W : RATIO_W + 1;
	localparam int LCNT_W  = $clog2(LOG_FRAC_BITS);
	localparam int DCNT_W  = $clog2(NUM_W);
	localparam int NIB     = 4;

	localparam logic [Q_W-1:0] MAX_POS_Q = Q_W'({1'b0, {(RATIO_W-1){1'b1}}});
	localparam logic [Q_W-1:0] MAX_NEG_Q = Q_W'({1'b1, {(RATIO_W-1){1'b0}}});

	// controller
	olrs_state_t state_q, state_d;

	// per-sample datapath
	logic [PRICE_W-1:0]       x_q;
	logic [LOG_INT_W-1:0]     pos_q;
	logic [LOG_FRAC_BITS-1:0] frac_q;
	logic [LCNT_W-1:0]        lcnt_q;
	logic                     present_q;
	logic                     last_q;

	// series state
	logic                     at_start_q;
	logic [LOG_W-1:0]         first_log_q;
	logic                     first_present_q;
	logic [LOG_W-1:0]         prev_log_q;
	logic                     prev_present_q;
	logic [PC_W-1:0]          pair_cnt_q;
	logic signed [SUM_W-1:0]  sum_q;

	// divider
	logic signed [LOG_W:0]    den_q;
	logic                     res_valid_q;
	logic                     neg_q;
	logic [NUM_W-1:0]         n_q;
	logic [LOG_W-1:0]         d_q;
	logic [LOG_W-1:0]         rem_q;
	logic [DCNT_W-1:0]        dcnt_q;

	// output register
	logic                     m_tvalid_q;
	logic [RATIO_W-1:0]       ratio_q;
	logic                     valid_res_q;

	// combinational helpers
	logic [2*PRICE_W-1:0]     prod;
	logic [PRICE_W:0]         sq;
	logic [LOG_W-1:0]         lg;
	logic [LOG_W-1:0]         first_eff;
	logic signed [SUM_W-1:0]  diff_ext;
	logic [SUM_W-1:0]         sum_abs;
	logic [LOG_W:0]           den_abs;
	logic [LOG_W:0]           rem_sh;
	logic [LOG_W:0]           rem_sub;
	logic                     qbit;
	logic [Q_W-1:0]           q_ext;
	logic [RATIO_W-1:0]       ratio_d;
	logic                     accept_in;
	logic                     out_free;

	assign accept_in = s_tvalid && (state_q == ST_IDLE);
	assign out_free  = !m_tvalid_q || m_tready;

	// squaring step: x in [1,2) as Q1.31, square and renormalise
	assign prod = x_q * x_q;
	assign sq   = prod[2*PRICE_W-1:PRICE_W-1];

	// log of the current sample and the first log of the series
	assign lg        = present_q ? {pos_q, frac_q} : '0;
	assign first_eff = at_start_q ? lg : first_log_q;
	assign diff_ext  = SUM_W'($signed({1'b0, lg})) - SUM_W'($signed({1'b0, prev_log_q}));

	// magnitudes for the divider
	assign sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign den_abs = den_q[LOG_W] ? (LOG_W+1)'(-den_q) : (LOG_W+1)'(den_q);

	// restoring division step, one quotient bit per cycle
	assign rem_sh  = {rem_q, n_q[NUM_W-1]};
	assign qbit    = rem_sh >= {1'b0, d_q};
	assign rem_sub = rem_sh - {1'b0, d_q};

	// sign and saturation of the quotient
	always_comb begin
		q_ext = Q_W'(n_q);
		if (!res_valid_q) begin
			ratio_d = '0;
		end else if (neg_q) begin
			ratio_d = (q_ext > MAX_NEG_Q) ? MAX_NEG_Q[RATIO_W-1:0] : RATIO_W'(-q_ext[RATIO_W-1:0]);
		end else begin
			ratio_d = (q_ext > MAX_POS_Q) ? MAX_POS_Q[RATIO_W-1:0] : q_ext[RATIO_W-1:0];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = (|s_tdata) ? ST_NORM : ST_ACC;
			end
			ST_NORM: begin
				if (x_q[PRICE_W-1]) state_d = ST_LOG;
			end
			ST_LOG: begin
				if (lcnt_q == '0) state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = last_q ? ST_PREP : ST_IDLE;
			end
			ST_PREP: begin
				state_d = res_valid_q ? ST_DIV : ST_FIN;
			end
			ST_DIV: begin
				if (dcnt_q == '0) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// series state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q      <= 1'b1;
			first_log_q     <= '0;
			first_present_q <= 1'b0;
			prev_log_q      <= '0;
			prev_present_q  <= 1'b0;
			pair_cnt_q      <= '0;
			sum_q           <= '0;
			m_tvalid_q      <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_ACC: begin
					if (at_start_q) begin
						first_log_q     <= lg;
						first_present_q <= present_q;
						at_start_q      <= 1'b0;
					end else if (pair_cnt_q < PC_W'(OPENING_RETURNS)) begin
						pair_cnt_q <= pair_cnt_q + 1'b1;
						if (prev_present_q && present_q) sum_q <= sum_q + diff_ext;
					end
					prev_log_q     <= lg;
					prev_present_q <= present_q;
				end
				ST_PREP: begin
					// series done: back to the start state
					at_start_q      <= 1'b1;
					first_log_q     <= '0;
					first_present_q <= 1'b0;
					prev_log_q      <= '0;
					prev_present_q  <= 1'b0;
					pair_cnt_q      <= '0;
					sum_q           <= '0;
				end
				ST_FIN: begin
					if (out_free) m_tvalid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					x_q       <= s_tdata;
					pos_q     <= LOG_INT_W'(PRICE_W - 1);
					frac_q    <= '0;
					present_q <= |s_tdata;
					last_q    <= s_tlast;
				end
			end
			ST_NORM: begin
				// leading-one search: a nibble at a time, then single bits
				if (x_q[PRICE_W-1]) begin
					lcnt_q <= LCNT_W'(LOG_FRAC_BITS - 1);
				end else if (x_q[PRICE_W-1 -: NIB] == '0) begin
					x_q   <= x_q << NIB;
					pos_q <= pos_q - LOG_INT_W'(NIB);
				end else begin
					x_q   <= x_q << 1;
					pos_q <= pos_q - 1'b1;
				end
			end
			ST_LOG: begin
				frac_q <= {frac_q[LOG_FRAC_BITS-2:0], sq[PRICE_W]};
				x_q    <= sq[PRICE_W] ? sq[PRICE_W:1] : sq[PRICE_W-1:0];
				lcnt_q <= lcnt_q - 1'b1;
			end
			ST_ACC: begin
				if (last_q) begin
					den_q       <= $signed({1'b0, lg}) - $signed({1'b0, first_eff});
					res_valid_q <= (at_start_q ? present_q : first_present_q) && present_q
						&& (lg != first_eff);
				end
			end
			ST_PREP: begin
				n_q    <= {sum_abs, {RATIO_FRAC{1'b0}}};
				d_q    <= den_abs[LOG_W-1:0];
				neg_q  <= sum_q[SUM_W-1] ^ den_q[LOG_W];
				rem_q  <= '0;
				dcnt_q <= DCNT_W'(NUM_W - 1);
			end
			ST_DIV: begin
				rem_q  <= qbit ? rem_sub[LOG_W-1:0] : rem_sh[LOG_W-1:0];
				n_q    <= {n_q[NUM_W-2:0], qbit};
				dcnt_q <= dcnt_q - 1'b1;
			end
			ST_FIN: begin
				if (out_free) begin
					ratio_q     <= ratio_d;
					valid_res_q <= res_valid_q;
				end
			end
			default: ;
		endcase
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = ratio_q;
	assign m_tuser[0] = valid_res_q;

	// checks
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("result without valid_res carries a nonzero ratio");

	a_mant_norm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOG |-> x_q[PRICE_W-1])
		else $error("mantissa not normalised during squaring");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> d_q != '0)
		else $error("divider running with zero divisor");

	a_pair_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pair_cnt_q <= PC_W'(OPENING_RETURNS))
		else $error("pair count beyond the opening window");

endmodule

FILE: tb/tb_opening_log_return_share.sv
// Self-checking testbench for opening_log_return_share: drives price series over the
// input stream and checks each share result against a built-in bit-exact predictor.
// Depends on olrs_pkg and the RTL top level; reads no files.
`timescale 1ns / 1ps

module tb_opening_log_return_share;
	import olrs_pkg::*;

	localparam int      LOG_W       = LOG_INT_W + LOG_FRAC_BITS_DEF;
	localparam longint  RATIO_MAX   = 64'sd2147483647;
	localparam longint  RATIO_MIN   = -64'sd2147483648;
	localparam int      PHASE_ITEMS = 400;
	localparam int      HOLD_CYCLES = 600;
	localparam int      CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic               valid_res;
	} share_t;

	// Predicts the share for each series and holds the results still to come
	class share_board;
		bit      at_start;
		longint  first_log;
		bit      first_present;
		longint  prev_log;
		bit      prev_present;
		int      pair_count;
		longint  return_sum;
		share_t  share_q[$];
		int      mismatches;

		function new();
			mismatches = 0;
			start_series();
		endfunction

		function void start_series();
			at_start      = 1'b1;
			first_log     = 0;
			first_present = 1'b0;
			prev_log      = 0;
			prev_present  = 1'b0;
			pair_count    = 0;
			return_sum    = 0;
		endfunction

		// log2 of a nonzero price: leading-one position, then truncating squarings
		function logic [LOG_W-1:0] log2_q16(logic [PRICE_W-1:0] p);
			logic [63:0]                  x;
			logic [LOG_FRAC_BITS_DEF-1:0] frac;
			int                           pos;
			pos = PRICE_W - 1;
			while (pos > 0 && p[pos] == 1'b0)
				pos--;
			x    = 64'(p) << (31 - pos);
			frac = '0;
			for (int i = 0; i < LOG_FRAC_BITS_DEF; i++) begin
				x    = (x * x) >> 31;
				frac = {frac[LOG_FRAC_BITS_DEF-2:0], 1'b0};
				if (x[63:32] != 0) begin
					frac[0] = 1'b1;
					x       = x >> 1;
				end
			end
			return {pos[LOG_INT_W-1:0], frac};
		endfunction

		function void note_sample(logic [PRICE_W-1:0] price, bit last);
			bit     present;
			bit     valid;
			longint cur_log;
			longint den;
			longint q;
			present = (price != 0);
			cur_log = present ? log2_q16(price) : 0;
			if (at_start) begin
				first_log     = cur_log;
				first_present = present;
				at_start      = 1'b0;
			end else if (pair_count < OPENING_RETURNS_DEF) begin
				pair_count++;
				if (prev_present && present)
					return_sum += cur_log - prev_log;
			end
			prev_log     = cur_log;
			prev_present = present;
			if (last) begin
				den   = cur_log - first_log;
				valid = first_present && present && den != 0;
				q     = 0;
				if (valid) begin
					q = (return_sum <<< RATIO_FRAC) / den;
					if (q > RATIO_MAX)
						q = RATIO_MAX;
					if (q < RATIO_MIN)
						q = RATIO_MIN;
				end
				share_q.push_back('{ratio: q[RATIO_W-1:0], valid_res: valid});
				start_series();
			end
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %0d at %0t: %s", mismatches, $realtime, msg);
		endfunction

		function void check_result(logic [RATIO_W-1:0] ratio, logic valid_res);
			share_t want;
			if (share_q.size() == 0) begin
				flag($sformatf("result with none pending: ratio %0d valid_res %0b",
					$signed(ratio), valid_res));
				return;
			end
			want = share_q.pop_front();
			if (want.ratio !== ratio)
				flag($sformatf("ratio expected %0d got %0d",
					$signed(want.ratio), $signed(ratio)));
			if (want.valid_res !== valid_res)
				flag($sformatf("valid_res expected %0b got %0b", want.valid_res, valid_res));
		endfunction

		function int pending();
			return share_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [PRICE_W-1:0] s_tdata;   // [31:0] price
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic [RATIO_W-1:0] m_tdata;   // [31:0] ratio (signed)
	logic [0:0]         m_tuser;   // [0] valid_res

	share_board board = new();
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;
	int         items_sent     = 0;
	int         cycle_count    = 0;
	bit         hold_go        = 1'b0;
	bit         hold_on        = 1'b0;

	opening_log_return_share u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Long receiver hold-off so the output register fills and the input stalls
	initial begin
		wait (hold_go);
		hold_on = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on = 1'b0;
	end

	// Receiver ready, random stalls
	always @(negedge clk) begin
		if (hold_on)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Result check
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser[0]);
	end

	// Offer one item, with random idle gaps ahead of it, and wait for acceptance
	task automatic send_sample(input logic [PRICE_W-1:0] price, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= price;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		board.note_sample(price, last);
		items_sent++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic send_prices(input logic [PRICE_W-1:0] prices[$]);
		for (int i = 0; i < prices.size(); i++)
			send_sample(prices[i], i == prices.size() - 1);
	endtask

	// Price mix: missing, small, powers of two, near the series opener, near full scale, otherwise random
	function automatic logic [PRICE_W-1:0] pick_price(logic [PRICE_W-1:0] anchor);
		case ($urandom_range(11))
			0:       return '0;
			1:       return PRICE_W'($urandom_range(1, 255));
			2:       return 32'h1 << $urandom_range(31);
			3:       return anchor + PRICE_W'($urandom_range(3));
			4:       return anchor;
			5:       return ~PRICE_W'($urandom_range(15));
			default: return $urandom();
		endcase
	endfunction

	// One series of random length: mostly short, some past the counted pairs
	task automatic send_series();
		logic [PRICE_W-1:0] anchor;
		int                 len;
		case ($urandom_range(9))
			0:       len = 1;
			7, 8:    len = $urandom_range(7, 12);
			9:       len = $urandom_range(13, 30);
			default: len = $urandom_range(2, 8);
		endcase
		anchor = pick_price($urandom());
		send_sample(anchor, len == 1);
		for (int i = 1; i < len; i++)
			send_sample(pick_price(anchor), i == len - 1);
	endtask

	initial begin
		logic [PRICE_W-1:0] seq_q[$];
		int                 phase_start;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed series
		seq_q = '{32'hFFFF_FFFF};                       // single sample
		send_prices(seq_q);
		seq_q = '{32'd0, 32'd1, 32'd5};                 // missing opener
		send_prices(seq_q);
		seq_q = '{32'd7, 32'd0};                        // missing closer
		send_prices(seq_q);
		seq_q = '{32'd64, 32'd128, 32'd64};             // zero denominator
		send_prices(seq_q);
		seq_q = '{32'd100, 32'd0, 32'd300, 32'd400};    // pairs with a gap
		send_prices(seq_q);
		// large positive sum over a tiny denominator
		seq_q = '{32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0002};
		send_prices(seq_q);
		// large negative sum over a tiny denominator
		seq_q = '{32'h8000_0000, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1,
			32'h8001_0000};
		send_prices(seq_q);
		stop_sending();
		while (board.pending() != 0)
			@(posedge clk);

		// Random series under each idling mix
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					hold_go        = 1'b1;
				end
				1: begin
					send_idle_pct  = 60;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 60;
				end
				default: begin
					send_idle_pct  = 30;
					recv_stall_pct = 30;
				end
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS)
				send_series();
			stop_sending();
			while (board.pending() != 0)
				@(posedge clk);
		end

		// Drain and let any late spurious result show
		repeat (100) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/olrs_pkg.sv
rtl/opening_log_return_share.sv
tb/tb_opening_log_return_share.sv
